// ===== src/sec_pkg.sv =====
// ---------------------------------------------------------------------------
// sec_pkg: shared types and codes for the SCAN elevator controller
// Request and result formats, stored rider format and result codes.
// ---------------------------------------------------------------------------
`default_nettype none

package sec_pkg;

    localparam int FLOOR_W = 4;
    localparam int ID_W    = 8;
    localparam int EV_W    = 3;

    localparam logic [EV_W-1:0] EV_ACCEPTED = 3'd0;
    localparam logic [EV_W-1:0] EV_FULL     = 3'd1;
    localparam logic [EV_W-1:0] EV_INVALID  = 3'd2;
    localparam logic [EV_W-1:0] EV_POSITION = 3'd3;
    localparam logic [EV_W-1:0] EV_ALIGHTED = 3'd4;
    localparam logic [EV_W-1:0] EV_BOARDED  = 3'd5;
    localparam logic [EV_W-1:0] EV_TURN     = 3'd6;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_TICK    = 1'b1;

    typedef struct packed {
        logic               cmd;
        logic [FLOOR_W-1:0] from_floor;
        logic [FLOOR_W-1:0] target_floor;
    } in_t;

    typedef struct packed {
        logic [EV_W-1:0]    event_res;
        logic [ID_W-1:0]    rider_id;
        logic [FLOOR_W-1:0] at_floor;
        logic [FLOOR_W-1:0] dest_floor;
        logic               going_up;
        logic               idle_flag;
        logic               last;
    } out_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [FLOOR_W-1:0] dest;
    } rider_t;

endpackage

`default_nettype wire

// ===== src/sec_hall_mem.sv =====
// ---------------------------------------------------------------------------
// sec_hall_mem: hall queue storage
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module sec_hall_mem
    import sec_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire rider_t            wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output rider_t                 rdata
);

    rider_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/scan_elevator_controller_unit.sv =====
// ---------------------------------------------------------------------------
// scan_elevator_controller_unit: one elevator car under SCAN scheduling
// Hall FIFOs per floor, riders in the car, walked by a sequencer one element at a time.
// ---------------------------------------------------------------------------
//  channel | signals                           | payload
//  --------+-----------------------------------+------------------------
//  input   | in_valid / in_ready / in_data     | in_t  (cmd, floors)
//  output  | out_valid / out_ready / out_data  | out_t (one result each)
//
//  A request passes through S_REQ and S_FLUSH. On a tick the sequencer
//  walks the car slots, the queue memory (one read port, registered data)
//  and every floor count in turn. in_ready is high only while the
//  sequencer is idle.
//  Output stalls hold the sequencer at the step that makes a result.
//  Reset clears counts, position and direction; queue and car slots are not.
// ---------------------------------------------------------------------------
`default_nettype none

module scan_elevator_controller_unit
    import sec_pkg::*;
#(
    parameter int FLOORS       = 16,
    parameter int QUEUE_DEPTH  = 4,
    parameter int CAR_CAPACITY = 4
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    localparam int HF     = (FLOORS < 16) ? FLOORS : 16;
    localparam int FI_W   = $clog2(HF);
    localparam int SC_W   = $clog2(HF + 1);
    localparam int QC_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int RC_W   = $clog2(CAR_CAPACITY + 1);
    localparam int CI_W   = (CAR_CAPACITY > 1) ? $clog2(CAR_CAPACITY) : 1;
    localparam int MDEPTH = HF * QUEUE_DEPTH;
    localparam int MA_W   = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
    localparam logic [6:0] FLOORS_V = 7'(FLOORS);
    localparam logic [QC_W-1:0] QD_V = QC_W'(QUEUE_DEPTH);
    localparam logic [RC_W-1:0] CAP_V = RC_W'(CAR_CAPACITY);
    localparam logic [SC_W-1:0] HF_V = SC_W'(HF);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_REQ   = 3'd1;
    localparam logic [2:0] S_ALI   = 3'd2;
    localparam logic [2:0] S_BRDRD = 3'd3;
    localparam logic [2:0] S_BRDEV = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_RSC   = 3'd6;
    localparam logic [2:0] S_FLUSH = 3'd7;

    logic [2:0]          state_reg, state_next;
    logic                dec_reg, dec_next;
    in_t                 req_reg, req_next;
    logic [QC_W-1:0]     hall_cnt_reg [HF];
    logic [QC_W-1:0]     hall_cnt_next [HF];
    rider_t              car_reg [CAR_CAPACITY];
    rider_t              car_next [CAR_CAPACITY];
    logic [RC_W-1:0]     rc_reg, rc_next;
    logic [FLOOR_W-1:0]  floor_reg, floor_next;
    logic                up_reg, up_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [RC_W-1:0]     i_reg, i_next;
    logic [RC_W-1:0]     n_reg, n_next;
    logic [QC_W-1:0]     j_reg, j_next;
    logic [QC_W-1:0]     k_reg, k_next;
    logic [QC_W-1:0]     cnt_reg, cnt_next;
    logic [SC_W-1:0]     s_reg, s_next;
    logic                wait_reg, wait_next;
    logic                ahead_reg, ahead_next;
    out_t                pend_reg, pend_next;
    out_t                out_reg, out_next;
    logic                ov_reg, ov_next;

    logic                out_free;
    logic [FI_W-1:0]     hc_addr;
    logic [QC_W-1:0]     hc_q;
    rider_t              car_q;
    logic                mem_we, mem_re;
    logic [MA_W-1:0]     mem_waddr, mem_raddr;
    rider_t              mem_wdata, mem_q;
    out_t                res;
    logic                push;

    function automatic logic headed(input logic [FLOOR_W-1:0] dest,
                                    input logic [FLOOR_W-1:0] fl,
                                    input logic up);
        return up ? (dest > fl) : (dest < fl);
    endfunction

    function automatic logic [MA_W-1:0] maddr(input logic [FLOOR_W-1:0] fl,
                                              input logic [QC_W-1:0] slot);
        return MA_W'(int'(fl[FI_W-1:0]) * QUEUE_DEPTH + int'(slot));
    endfunction

    sec_hall_mem #(.DEPTH(MDEPTH), .ADDR_W(MA_W)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_data  = out_reg;
    assign out_free  = !ov_reg || out_ready;

    always_comb
    begin
        unique case (state_reg)
            S_IDLE:  hc_addr = in_data.from_floor[FI_W-1:0];
            S_REQ:   hc_addr = req_reg.from_floor[FI_W-1:0];
            S_SCAN:  hc_addr = s_reg[FI_W-1:0];
            default: hc_addr = floor_reg[FI_W-1:0];
        endcase
        hc_q  = hall_cnt_reg[hc_addr];
        car_q = car_reg[i_reg[CI_W-1:0]];
    end

    always_comb
    begin
        state_next = state_reg;
        dec_next   = dec_reg;
        req_next   = req_reg;
        hall_cnt_next = hall_cnt_reg;
        car_next   = car_reg;
        rc_next    = rc_reg;
        floor_next = floor_reg;
        up_next    = up_reg;
        id_next    = id_reg;
        i_next     = i_reg;
        n_next     = n_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        wait_next  = wait_reg;
        ahead_next = ahead_reg;
        pend_next  = pend_reg;
        mem_we     = 1'b0;
        mem_waddr  = maddr(req_reg.from_floor, hc_q);
        mem_wdata  = '{id: id_reg + 8'd1, dest: req_reg.target_floor};
        mem_re     = 1'b0;
        mem_raddr  = maddr(floor_reg, j_reg);
        res        = '0;
        push       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next = in_data;
                    if (in_data.cmd == CMD_TICK)
                    begin
                        pend_next = '{event_res: EV_POSITION, rider_id: '0,
                                      at_floor: floor_reg, dest_floor: '0,
                                      going_up: up_reg, idle_flag: 1'b0,
                                      last: 1'b0};
                        i_next     = '0;
                        n_next     = '0;
                        state_next = S_ALI;
                    end
                    else
                    begin
                        state_next = S_REQ;
                    end
                end
            end
            S_REQ:
            begin
                if (req_reg.from_floor == req_reg.target_floor
                    || {3'b000, req_reg.from_floor} >= FLOORS_V
                    || {3'b000, req_reg.target_floor} >= FLOORS_V)
                begin
                    pend_next = '{event_res: EV_INVALID, rider_id: '0,
                                  at_floor: req_reg.from_floor,
                                  dest_floor: req_reg.target_floor, going_up: up_reg,
                                  idle_flag: 1'b0, last: 1'b0};
                end
                else
                begin
                    id_next   = id_reg + 8'd1;
                    pend_next = '{event_res: EV_ACCEPTED, rider_id: id_reg + 8'd1,
                                  at_floor: req_reg.from_floor,
                                  dest_floor: req_reg.target_floor, going_up: up_reg,
                                  idle_flag: 1'b0, last: 1'b0};
                    if (hc_q >= QD_V)
                    begin
                        pend_next.event_res = EV_FULL;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        hall_cnt_next[hc_addr] = hc_q + 1'b1;
                    end
                end
                state_next = S_FLUSH;
            end
            S_ALI:
            begin
                if (i_reg == rc_reg)
                begin
                    rc_next    = n_reg;
                    j_next     = '0;
                    k_next     = '0;
                    cnt_next   = hc_q;
                    state_next = S_BRDRD;
                end
                else if (car_q.dest == floor_reg)
                begin
                    res = '{event_res: EV_ALIGHTED, rider_id: car_q.id,
                            at_floor: floor_reg, dest_floor: car_q.dest,
                            going_up: up_reg, idle_flag: 1'b0, last: 1'b0};
                    if (out_free)
                    begin
                        push   = 1'b1;
                        i_next = i_reg + 1'b1;
                    end
                end
                else
                begin
                    car_next[n_reg[CI_W-1:0]] = car_q;
                    n_next = n_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                end
            end
            S_BRDRD:
            begin
                if (j_reg == cnt_reg)
                begin
                    hall_cnt_next[hc_addr] = k_reg;
                    s_next     = '0;
                    wait_next  = 1'b0;
                    ahead_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_BRDEV;
                end
            end
            S_BRDEV:
            begin
                if (rc_reg < CAP_V && headed(mem_q.dest, floor_reg, up_reg))
                begin
                    res = '{event_res: EV_BOARDED, rider_id: mem_q.id,
                            at_floor: floor_reg, dest_floor: mem_q.dest,
                            going_up: up_reg, idle_flag: 1'b0, last: 1'b0};
                    if (out_free)
                    begin
                        push = 1'b1;
                        car_next[rc_reg[CI_W-1:0]] = mem_q;
                        rc_next    = rc_reg + 1'b1;
                        j_next     = j_reg + 1'b1;
                        state_next = S_BRDRD;
                    end
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = maddr(floor_reg, k_reg);
                    mem_wdata  = mem_q;
                    k_next     = k_reg + 1'b1;
                    j_next     = j_reg + 1'b1;
                    state_next = S_BRDRD;
                end
            end
            S_SCAN:
            begin
                if (s_reg == HF_V)
                begin
                    i_next     = '0;
                    dec_next   = 1'b0;
                    state_next = S_RSC;
                end
                else
                begin
                    if (hc_q != '0)
                    begin
                        wait_next = 1'b1;
                        if (up_reg ? (s_reg > SC_W'(floor_reg))
                                   : (s_reg < SC_W'(floor_reg)))
                        begin
                            ahead_next = 1'b1;
                        end
                    end
                    s_next = s_reg + 1'b1;
                end
            end
            S_RSC:
            begin
                if (dec_reg)
                begin
                    if (!wait_reg && rc_reg == '0)
                    begin
                        res = '{event_res: EV_TURN, rider_id: '0, at_floor: floor_reg,
                                dest_floor: '0, going_up: up_reg, idle_flag: 1'b1,
                                last: 1'b0};
                        if (out_free)
                        begin
                            push       = 1'b1;
                            state_next = S_FLUSH;
                        end
                    end
                    else if (!ahead_reg)
                    begin
                        res = '{event_res: EV_TURN, rider_id: '0, at_floor: floor_reg,
                                dest_floor: '0, going_up: !up_reg, idle_flag: 1'b0,
                                last: 1'b0};
                        if (out_free)
                        begin
                            push       = 1'b1;
                            up_next    = !up_reg;
                            state_next = S_FLUSH;
                        end
                    end
                    else
                    begin
                        floor_next = up_reg ? floor_reg + 1'b1 : floor_reg - 1'b1;
                        state_next = S_FLUSH;
                    end
                end
                else if (i_reg == rc_reg)
                begin
                    dec_next = 1'b1;
                end
                else
                begin
                    if (headed(car_q.dest, floor_reg, up_reg))
                    begin
                        ahead_next = 1'b1;
                    end
                    i_next = i_reg + 1'b1;
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // hand the held result to the output, keep the newest one back
        ov_next  = ov_reg && !out_ready;
        out_next = out_reg;
        if (push)
        begin
            out_next  = pend_reg;
            ov_next   = 1'b1;
            pend_next = res;
        end
        else if (state_reg == S_FLUSH && out_free)
        begin
            out_next      = pend_reg;
            out_next.last = 1'b1;
            ov_next       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            dec_reg    <= 1'b0;
            rc_reg     <= '0;
            floor_reg  <= '0;
            up_reg     <= 1'b1;
            id_reg     <= '0;
            ov_reg     <= 1'b0;
            for (int f = 0; f < HF; f++)
            begin
                hall_cnt_reg[f] <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            dec_reg      <= dec_next;
            rc_reg       <= rc_next;
            floor_reg    <= floor_next;
            up_reg       <= up_next;
            id_reg       <= id_next;
            ov_reg       <= ov_next;
            hall_cnt_reg <= hall_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg   <= req_next;
        car_reg   <= car_next;
        i_reg     <= i_next;
        n_reg     <= n_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        cnt_reg   <= cnt_next;
        s_reg     <= s_next;
        wait_reg  <= wait_next;
        ahead_reg <= ahead_next;
        pend_reg  <= pend_next;
        out_reg   <= out_next;
    end

endmodule

`default_nettype wire
